[sv/ihex_pkg.sv]
// Package for the HEX record line parser: shared constants, codes, types and helpers.
// Used by the front end, queue, back end and top level of the parser; depends on nothing.
`default_nettype none

package ihex_pkg;

   // Size of the per-line data buffer, in bytes
   localparam int MAX_DATA_BYTES_DEFAULT = 32;

   // Reset value of the memory limit register
   localparam logic [32:0] MEMORY_LIMIT_RESET = 33'h0_0002_0000;

   // Character positions and fixed characters of a record line
   localparam logic [9:0] POS_SATURATED = 10'd1023;
   localparam logic [9:0] POS_TYPE      = 10'd8;
   localparam logic [9:0] LINE_OVERHEAD = 10'd11;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] TYPE_DATA     = 8'h30;
   localparam logic [7:0] TYPE_EOF      = 8'h31;
   localparam logic [7:0] TYPE_EXT_LIN  = 8'h34;
   localparam logic [7:0] TYPE_START    = 8'h35;
   localparam logic [7:0] EXT_LEN       = 8'd2;
   localparam logic [7:0] START_LEN     = 8'd4;

   // Pair indexes of the header fields
   localparam logic [8:0] PAIR_LENGTH    = 9'd0;
   localparam logic [8:0] PAIR_ADDR_HIGH = 9'd1;
   localparam logic [8:0] PAIR_ADDR_LOW  = 9'd2;
   localparam logic [8:0] PAIR_TYPE      = 9'd3;
   localparam logic [8:0] PAIR_DATA      = 9'd4;

   // Configuration register index, taken from paddr[3]
   localparam logic CSR_MEMORY_LIMIT = 1'b0;

   // Result kinds
   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Record status codes
   localparam logic [3:0] ST_DATA_OK   = 4'd0;
   localparam logic [3:0] ST_EXT_OK    = 4'd1;
   localparam logic [3:0] ST_START_OK  = 4'd2;
   localparam logic [3:0] ST_EOF       = 4'd3;
   localparam logic [3:0] ST_UNKNOWN   = 4'd4;
   localparam logic [3:0] ST_LENGTH    = 4'd5;
   localparam logic [3:0] ST_CHECKSUM  = 4'd6;
   localparam logic [3:0] ST_BOUNDS    = 4'd7;
   localparam logic [3:0] ST_BAD_EXT   = 4'd8;
   localparam logic [3:0] ST_BAD_START = 4'd9;
   localparam logic [3:0] ST_TOO_LONG  = 4'd10;

   // Summary of one finished line, passed from the front end to the back end
   typedef struct packed {
      logic        length_ok;
      logic        sum_ok;
      logic [7:0]  length;
      logic [15:0] offset;
      logic [7:0]  type_char;
      logic        bank;
   } line_desc_type;

   // Back end sequencer states
   typedef enum logic [2:0] {
      B_IDLE,
      B_JUDGE,
      B_READ,
      B_TAKE,
      B_APPLY,
      B_STATUS
   } back_state_type;

   // Value of one hex digit; anything that is not a hex digit counts as zero.
   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
      else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
      else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
      return v;
   endfunction

   // Counter increment that sticks at all ones.
   function automatic logic [15:0] sat_inc16(input logic [15:0] v);
      logic [15:0] r;
      r = (v == 16'hFFFF) ? v : v + 16'd1;
      return r;
   endfunction

endpackage

`default_nettype wire

[sv/ihex_req_if.sv]
// Request channel of the parser: one line character per request, with a line end flag.
// Depends on nothing outside this file.
`default_nettype none

interface ihex_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       line_end;

   modport source (output valid, output ch, output line_end, input ready);
   modport sink   (input valid, input ch, input line_end, output ready);
endinterface

`default_nettype wire

[sv/ihex_rsp_if.sv]
// Result channel of the parser: byte writes and per-line status items.
// Depends on nothing outside this file.
`default_nettype none

interface ihex_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [31:0] write_address;
   logic [7:0]  write_data;
   logic [3:0]  status;
   logic [7:0]  record_type;
   logic [31:0] start_address;
   logic [15:0] error_total;
   logic [15:0] checksum_error_total;
   logic [15:0] record_total;
   logic [31:0] bytes_written_total;
   logic        last;

   modport source (output valid, output kind, output write_address, output write_data,
                   output status, output record_type, output start_address,
                   output error_total, output checksum_error_total, output record_total,
                   output bytes_written_total, output last, input ready);
   modport sink   (input valid, input kind, input write_address, input write_data,
                   input status, input record_type, input start_address,
                   input error_total, input checksum_error_total, input record_total,
                   input bytes_written_total, input last, output ready);
endinterface

`default_nettype wire

[sv/ihex_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; used for the line data buffer of the parser.
`default_nettype none

module ihex_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

[sv/ihex_front.sv]
// Front end of the parser: takes characters, decodes hex pairs, fills the data buffer
// and hands a line summary on at each line end. Depends on ihex_pkg and ihex_req_if.
`default_nettype none

module ihex_front #(
   parameter int MAX_DATA_BYTES = ihex_pkg::MAX_DATA_BYTES_DEFAULT,
   localparam int IDX_W = $clog2(MAX_DATA_BYTES)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   ihex_req_if.sink                   req_chan,
   input  wire logic                  queue_full,
   output logic                       push,
   output ihex_pkg::line_desc_type    push_desc,
   output logic                       buf_we,
   output logic [IDX_W:0]             buf_waddr,
   output logic [7:0]                 buf_wdata
);
   import ihex_pkg::*;

   localparam logic [8:0] PAIR_DATA_END = 9'(4 + MAX_DATA_BYTES);

   logic [9:0]  pos_ff,  pos_in;
   logic [3:0]  hi_ff,   hi_in;
   logic [7:0]  len_ff,  len_in;
   logic [15:0] off_ff,  off_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  sum_ff,  sum_in;
   logic        bank_ff, bank_in;

   logic        accept;
   logic [3:0]  nib;
   logic [7:0]  pair;
   logic [8:0]  k;
   logic [9:0]  expected;
   logic [8:0]  data_idx;

   assign req_chan.ready = !queue_full;
   assign accept = req_chan.valid && req_chan.ready;

   // Character decode and line state update
   always_comb begin
      pos_in    = pos_ff;
      hi_in     = hi_ff;
      len_in    = len_ff;
      off_in    = off_ff;
      type_in   = type_ff;
      sum_in    = sum_ff;
      bank_in   = bank_ff;
      buf_we    = 1'b0;
      nib       = hex_nibble(req_chan.ch);
      pair      = {hi_ff, nib};
      k         = 9'((pos_ff - 10'd2) >> 1);
      data_idx  = k - PAIR_DATA;
      buf_waddr = {bank_ff, data_idx[IDX_W-1:0]};
      buf_wdata = pair;
      push      = 1'b0;
      expected  = 10'd0;
      push_desc = '0;

      if (accept && pos_ff != POS_SATURATED) begin
         if (pos_ff == POS_TYPE) begin
            type_in = req_chan.ch;
         end
         if (pos_ff[0]) begin
            hi_in = nib;
         end else if (pos_ff >= 10'd2) begin
            unique case (k)
               PAIR_LENGTH:    len_in = pair;
               PAIR_ADDR_HIGH: off_in = {pair, off_ff[7:0]};
               PAIR_ADDR_LOW:  off_in = {off_ff[15:8], pair};
               default: begin
                  if (k >= PAIR_DATA && k < PAIR_DATA_END) begin
                     buf_we = 1'b1;
                  end
               end
            endcase
            if (k != PAIR_TYPE) begin
               sum_in = sum_ff + pair;
            end
         end
         pos_in = pos_ff + 10'd1;
      end

      // At the line end the summary leaves and the line state starts afresh
      if (accept && req_chan.line_end) begin
         expected            = LINE_OVERHEAD + {1'b0, len_in, 1'b0};
         push                = 1'b1;
         push_desc.length_ok = (pos_in == expected);
         push_desc.sum_ok    = (8'(sum_in + type_in - CHAR_ZERO) == 8'd0);
         push_desc.length    = len_in;
         push_desc.offset    = off_in;
         push_desc.type_char = type_in;
         push_desc.bank      = bank_ff;
         pos_in  = 10'd0;
         hi_in   = 4'd0;
         len_in  = 8'd0;
         off_in  = 16'd0;
         type_in = 8'd0;
         sum_in  = 8'd0;
         bank_in = !bank_ff;
      end
   end

   // Line state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 10'd0;
         hi_ff   <= 4'd0;
         len_ff  <= 8'd0;
         off_ff  <= 16'd0;
         type_ff <= 8'd0;
         sum_ff  <= 8'd0;
         bank_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         hi_ff   <= hi_in;
         len_ff  <= len_in;
         off_ff  <= off_in;
         type_ff <= type_in;
         sum_ff  <= sum_in;
         bank_ff <= bank_in;
      end
   end

endmodule

`default_nettype wire

[sv/ihex_queue.sv]
// One-entry holding queue for line summaries between the front and back ends.
// Depends on ihex_pkg.
`default_nettype none

module ihex_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire ihex_pkg::line_desc_type push_desc,
   output logic                         full,
   input  wire logic                    pop,
   output ihex_pkg::line_desc_type      head
);
   import ihex_pkg::*;

   logic          full_ff, full_in;
   line_desc_type desc_ff;

   assign full = full_ff;
   assign head = desc_ff;

   // Occupancy: a push only happens while empty
   always_comb begin
      full_in = full_ff;
      if (pop) full_in = 1'b0;
      if (push) full_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         desc_ff <= push_desc;
      end
   end

endmodule

`default_nettype wire

[sv/ihex_back.sv]
// Back end of the parser: judges each finished line, replays data bytes from the buffer
// and emits the status item. Depends on ihex_pkg and ihex_rsp_if.
`default_nettype none

module ihex_back #(
   parameter int MAX_DATA_BYTES = ihex_pkg::MAX_DATA_BYTES_DEFAULT,
   localparam int IDX_W = $clog2(MAX_DATA_BYTES)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    line_valid,
   input  wire ihex_pkg::line_desc_type line_head,
   output logic                         line_pop,
   input  wire logic [32:0]             memory_limit,
   output logic [IDX_W:0]               buf_raddr,
   input  wire logic [7:0]              buf_rdata,
   ihex_rsp_if.source                   rsp_chan
);
   import ihex_pkg::*;

   localparam logic [7:0] MAX_LEN = 8'(MAX_DATA_BYTES);

   back_state_type state_ff, state_in;
   line_desc_type  desc_ff, desc_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [31:0] acc_ff, acc_in;
   logic [3:0]  status_ff, status_in;
   logic [15:0] upper_ff, upper_in;
   logic [31:0] start_ff, start_in;
   logic [15:0] err_ff, err_in;
   logic [15:0] csum_ff, csum_in;
   logic [15:0] rec_ff, rec_in;
   logic [31:0] bytes_ff, bytes_in;

   logic        out_valid_ff, out_valid_in;
   logic        out_kind_ff, out_kind_in;
   logic [31:0] out_addr_ff, out_addr_in;
   logic [7:0]  out_data_ff, out_data_in;
   logic [3:0]  out_status_ff, out_status_in;
   logic [7:0]  out_type_ff, out_type_in;
   logic [31:0] out_start_ff, out_start_in;
   logic [15:0] out_err_ff, out_err_in;
   logic [15:0] out_csum_ff, out_csum_in;
   logic [15:0] out_rec_ff, out_rec_in;
   logic [31:0] out_bytes_ff, out_bytes_in;
   logic        out_last_ff, out_last_in;

   logic        slot_free;
   logic        load_out;
   logic [31:0] base_addr;
   logic [32:0] end_addr;
   logic        last_byte;

   assign slot_free = !out_valid_ff || rsp_chan.ready;
   assign base_addr = {upper_ff, desc_ff.offset};
   assign end_addr  = {1'b0, base_addr} + 33'(desc_ff.length);
   assign last_byte = (8'(idx_ff) == desc_ff.length - 8'd1);
   assign buf_raddr = {desc_ff.bank, idx_ff};

   // Sequencer: next state, architectural state and output register loads
   always_comb begin
      state_in      = state_ff;
      desc_in       = desc_ff;
      idx_in        = idx_ff;
      acc_in        = acc_ff;
      status_in     = status_ff;
      upper_in      = upper_ff;
      start_in      = start_ff;
      err_in        = err_ff;
      csum_in       = csum_ff;
      rec_in        = rec_ff;
      bytes_in      = bytes_ff;
      line_pop      = 1'b0;
      load_out      = 1'b0;
      out_kind_in   = out_kind_ff;
      out_addr_in   = out_addr_ff;
      out_data_in   = out_data_ff;
      out_status_in = out_status_ff;
      out_type_in   = out_type_ff;
      out_start_in  = out_start_ff;
      out_err_in    = out_err_ff;
      out_csum_in   = out_csum_ff;
      out_rec_in    = out_rec_ff;
      out_bytes_in  = out_bytes_ff;
      out_last_in   = out_last_ff;

      unique case (state_ff)
         B_IDLE: begin
            if (line_valid) begin
               line_pop = 1'b1;
               desc_in  = line_head;
               idx_in   = '0;
               state_in = B_JUDGE;
            end
         end

         // Checks in priority order: length, buffer size, checksum, then record type
         B_JUDGE: begin
            state_in = B_STATUS;
            if (!desc_ff.length_ok) begin
               err_in    = sat_inc16(err_ff);
               status_in = ST_LENGTH;
            end else if (desc_ff.length > MAX_LEN) begin
               err_in    = sat_inc16(err_ff);
               status_in = ST_TOO_LONG;
            end else if (!desc_ff.sum_ok) begin
               csum_in   = sat_inc16(csum_ff);
               status_in = ST_CHECKSUM;
            end else begin
               rec_in = sat_inc16(rec_ff);
               if (desc_ff.type_char == TYPE_DATA) begin
                  if (end_addr > memory_limit) begin
                     err_in    = sat_inc16(err_ff);
                     status_in = ST_BOUNDS;
                  end else begin
                     bytes_in  = bytes_ff + 32'(desc_ff.length);
                     status_in = ST_DATA_OK;
                     if (desc_ff.length != 8'd0) state_in = B_READ;
                  end
               end else if (desc_ff.type_char == TYPE_EXT_LIN) begin
                  if (desc_ff.length != EXT_LEN) begin
                     err_in    = sat_inc16(err_ff);
                     status_in = ST_BAD_EXT;
                  end else begin
                     status_in = ST_EXT_OK;
                     state_in  = B_READ;
                  end
               end else if (desc_ff.type_char == TYPE_START) begin
                  if (desc_ff.length != START_LEN) begin
                     status_in = ST_BAD_START;
                  end else begin
                     status_in = ST_START_OK;
                     state_in  = B_READ;
                  end
               end else if (desc_ff.type_char == TYPE_EOF) begin
                  status_in = ST_EOF;
               end else begin
                  status_in = ST_UNKNOWN;
               end
            end
         end

         // The buffer address is presented here; its data is ready in the next cycle
         B_READ: begin
            state_in = B_TAKE;
         end

         // Data bytes become write items; address bytes are gathered for the update
         B_TAKE: begin
            if (status_ff == ST_DATA_OK) begin
               if (slot_free) begin
                  load_out      = 1'b1;
                  out_kind_in   = KIND_WRITE;
                  out_addr_in   = base_addr + 32'(idx_ff);
                  out_data_in   = buf_rdata;
                  out_status_in = 4'd0;
                  out_type_in   = 8'd0;
                  out_start_in  = 32'd0;
                  out_err_in    = 16'd0;
                  out_csum_in   = 16'd0;
                  out_rec_in    = 16'd0;
                  out_bytes_in  = 32'd0;
                  out_last_in   = 1'b0;
                  idx_in        = idx_ff + 1'b1;
                  state_in      = last_byte ? B_STATUS : B_READ;
               end
            end else begin
               acc_in   = {acc_ff[23:0], buf_rdata};
               idx_in   = idx_ff + 1'b1;
               state_in = last_byte ? B_APPLY : B_READ;
            end
         end

         B_APPLY: begin
            if (status_ff == ST_EXT_OK) begin
               upper_in = acc_ff[15:0];
            end else begin
               start_in = acc_ff;
            end
            state_in = B_STATUS;
         end

         B_STATUS: begin
            if (slot_free) begin
               load_out      = 1'b1;
               out_kind_in   = KIND_STATUS;
               out_addr_in   = 32'd0;
               out_data_in   = 8'd0;
               out_status_in = status_ff;
               out_type_in   = desc_ff.type_char;
               out_start_in  = start_ff;
               out_err_in    = err_ff;
               out_csum_in   = csum_ff;
               out_rec_in    = rec_ff;
               out_bytes_in  = bytes_ff;
               out_last_in   = 1'b1;
               state_in      = B_IDLE;
            end
         end

         default: state_in = B_IDLE;
      endcase

      out_valid_in = out_valid_ff && !rsp_chan.ready;
      if (load_out) out_valid_in = 1'b1;
   end

   // Control state and the cross-line registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
         upper_ff     <= 16'd0;
         start_ff     <= 32'd0;
         err_ff       <= 16'd0;
         csum_ff      <= 16'd0;
         rec_ff       <= 16'd0;
         bytes_ff     <= 32'd0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         upper_ff     <= upper_in;
         start_ff     <= start_in;
         err_ff       <= err_in;
         csum_ff      <= csum_in;
         rec_ff       <= rec_in;
         bytes_ff     <= bytes_in;
      end
   end

   // Working and output payload registers
   always_ff @(posedge clock) begin
      desc_ff       <= desc_in;
      idx_ff        <= idx_in;
      acc_ff        <= acc_in;
      status_ff     <= status_in;
      out_kind_ff   <= out_kind_in;
      out_addr_ff   <= out_addr_in;
      out_data_ff   <= out_data_in;
      out_status_ff <= out_status_in;
      out_type_ff   <= out_type_in;
      out_start_ff  <= out_start_in;
      out_err_ff    <= out_err_in;
      out_csum_ff   <= out_csum_in;
      out_rec_ff    <= out_rec_in;
      out_bytes_ff  <= out_bytes_in;
      out_last_ff   <= out_last_in;
   end

   // Result channel
   assign rsp_chan.valid                = out_valid_ff;
   assign rsp_chan.kind                 = out_kind_ff;
   assign rsp_chan.write_address        = out_addr_ff;
   assign rsp_chan.write_data           = out_data_ff;
   assign rsp_chan.status               = out_status_ff;
   assign rsp_chan.record_type          = out_type_ff;
   assign rsp_chan.start_address        = out_start_ff;
   assign rsp_chan.error_total          = out_err_ff;
   assign rsp_chan.checksum_error_total = out_csum_ff;
   assign rsp_chan.record_total         = out_rec_ff;
   assign rsp_chan.bytes_written_total  = out_bytes_ff;
   assign rsp_chan.last                 = out_last_ff;

endmodule

`default_nettype wire

[sv/intel_hex_record_parser.sv]
// Top level of the HEX record line parser: front end, line queue, data buffer RAM,
// back end and the memory limit register. Depends on ihex_pkg and all ihex_* files.
//
//   Channel   Direction  Handshake               Carries
//   req_chan  in         valid/ready             ch, line_end: one line character
//   rsp_chan  out        valid/ready             byte writes, then one status item
//   APB       in         psel/penable/pwrite     memory_limit at byte address 0
//
// Characters are taken at one per cycle while the line queue has room. At a line end
// the back end pops the queue and judges the line, then for each data byte reads the
// buffer and loads an output item, and last loads the status item; an extended or start
// address record reads and gathers each address byte, then applies the new value.
// The data buffer has two banks, so the next line streams in while the back end replays
// the previous one. Request ready drops for one cycle after every line end, while the
// finished line sits in the queue, and stays low while it waits behind the one in progress.
// Reset is synchronous and clears all control state and counters; no clearing pass.
`default_nettype none

module intel_hex_record_parser #(
   parameter int MAX_DATA_BYTES = ihex_pkg::MAX_DATA_BYTES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   ihex_req_if.sink         req_chan,
   ihex_rsp_if.source       rsp_chan,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [63:0] pwdata,
   output logic      [63:0] prdata,
   output logic             pready
);
   import ihex_pkg::*;

   localparam int IDX_W     = $clog2(MAX_DATA_BYTES);
   localparam int BUF_DEPTH = 2 * (2 ** IDX_W);

   logic [32:0]   limit_ff, limit_in;
   logic          q_push, q_full, q_pop;
   line_desc_type q_push_desc, q_head;
   logic          buf_we;
   logic [IDX_W:0] buf_waddr, buf_raddr;
   logic [7:0]    buf_wdata, buf_rdata;

   // Configuration register
   assign pready = 1'b1;
   assign prdata = (paddr[3] == CSR_MEMORY_LIMIT) ? {31'd0, limit_ff} : 64'd0;

   always_comb begin
      limit_in = limit_ff;
      if (psel && penable && pwrite && paddr[3] == CSR_MEMORY_LIMIT) begin
         limit_in = pwdata[32:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= MEMORY_LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   // Character intake
   ihex_front #(.MAX_DATA_BYTES(MAX_DATA_BYTES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (q_full),
      .push       (q_push),
      .push_desc  (q_push_desc),
      .buf_we     (buf_we),
      .buf_waddr  (buf_waddr),
      .buf_wdata  (buf_wdata)
   );

   // Finished-line queue
   ihex_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_push_desc),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head)
   );

   // Two-bank data buffer
   ihex_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_buffer (
      .clock (clock),
      .we    (buf_we),
      .waddr (buf_waddr),
      .wdata (buf_wdata),
      .raddr (buf_raddr),
      .rdata (buf_rdata)
   );

   // Line judgement and result generation
   ihex_back #(.MAX_DATA_BYTES(MAX_DATA_BYTES)) u_back (
      .clock        (clock),
      .reset        (reset),
      .line_valid   (q_full),
      .line_head    (q_head),
      .line_pop     (q_pop),
      .memory_limit (limit_ff),
      .buf_raddr    (buf_raddr),
      .buf_rdata    (buf_rdata),
      .rsp_chan     (rsp_chan)
   );

endmodule

`default_nettype wire

[sim/intel_hex_record_parser_tb.sv]
// Self-checking testbench for the HEX record line parser: streams record lines through the
// request channel and checks every write and status item against an in-bench line model.
// Depends on ihex_pkg, ihex_req_if, ihex_rsp_if and intel_hex_record_parser.
`default_nettype none

module intel_hex_record_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ihex_pkg::*;

   localparam int          BUF_BYTES    = MAX_DATA_BYTES_DEFAULT;
   localparam int unsigned CYCLE_LIMIT  = 2_000_000;
   localparam int          DRAIN_CYCLES = 100;
   localparam int          LINE_MAX_POS = 1023;

   // One item on the result channel, as the model predicts it
   typedef struct packed {
      logic        kind;
      logic [31:0] address;
      logic [7:0]  data;
      logic [3:0]  status;
      logic [7:0]  rtype;
      logic [31:0] start;
      logic [15:0] errors;
      logic [15:0] cks_errors;
      logic [15:0] records;
      logic [31:0] bytes;
      logic        last;
   } hex_result_type;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [63:0] pwdata;
   logic [63:0] prdata;
   logic        pready;

   ihex_req_if req_bus ();
   ihex_rsp_if rsp_bus ();

   intel_hex_record_parser dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Line model state: the line being decoded and the values kept across lines
   int unsigned line_pos;
   logic [3:0]  high_digit;
   logic [7:0]  length_byte;
   logic [15:0] line_offset;
   logic [7:0]  type_letter;
   logic [7:0]  byte_sum;
   logic [7:0]  line_bytes [BUF_BYTES];
   logic [15:0] upper_half;
   logic [31:0] entry_point;
   logic [15:0] error_tally;
   logic [15:0] checksum_tally;
   logic [15:0] record_tally;
   logic [31:0] bytes_tally;
   logic [32:0] limit_value;

   hex_result_type pending_outputs [$];
   int          failures;
   int unsigned cycle_count;
   int unsigned chars_sent;
   bit          sender_idles;
   bit          receiver_stalls;
   logic [7:0]  payload [256];
   logic [7:0]  line_text [$];

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Result side back-pressure: mostly ready, short stalls and the odd long one
   initial begin
      int pick;
      int stall_left;
      rsp_bus.ready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (!receiver_stalls) begin
            rsp_bus.ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               rsp_bus.ready <= 1'b1;
            end else begin
               rsp_bus.ready <= 1'b0;
               stall_left = (pick < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic string describe(input hex_result_type r);
      return $sformatf({"kind=%0d addr=%h data=%h status=%0d type=%h start=%h ",
                        "err=%0d cks=%0d rec=%0d bytes=%0d last=%0d"},
                       r.kind, r.address, r.data, r.status, r.rtype, r.start,
                       r.errors, r.cks_errors, r.records, r.bytes, r.last);
   endfunction

   task automatic log_failure(input string text);
      failures++;
      if (failures <= 10) $display("%s", text);
   endtask

   // Compare each accepted result with the oldest predicted one
   always @(posedge clock) begin
      hex_result_type seen;
      hex_result_type wanted;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.kind       = rsp_bus.kind;
         seen.address    = rsp_bus.write_address;
         seen.data       = rsp_bus.write_data;
         seen.status     = rsp_bus.status;
         seen.rtype      = rsp_bus.record_type;
         seen.start      = rsp_bus.start_address;
         seen.errors     = rsp_bus.error_total;
         seen.cks_errors = rsp_bus.checksum_error_total;
         seen.records    = rsp_bus.record_total;
         seen.bytes      = rsp_bus.bytes_written_total;
         seen.last       = rsp_bus.last;
         if (pending_outputs.size() == 0) begin
            log_failure({"unexpected result: ", describe(seen)});
         end else begin
            wanted = pending_outputs.pop_front();
            if (seen !== wanted) begin
               log_failure($sformatf("result mismatch\n  expected %s\n  actual   %s",
                                     describe(wanted), describe(seen)));
            end
         end
      end
   end

   // ---------------------------------------------------------------- line model

   function automatic logic [3:0] digit_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return c[3:0];
      if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) return 4'(c[3:0] + 4'd9);
      return 4'd0;
   endfunction

   function automatic logic [15:0] count_up(input logic [15:0] v);
      return (&v) ? v : v + 16'd1;
   endfunction

   task automatic clear_line_state;
      line_pos    = 0;
      high_digit  = '0;
      length_byte = '0;
      line_offset = '0;
      type_letter = '0;
      byte_sum    = '0;
   endtask

   task automatic reset_model;
      clear_line_state();
      foreach (line_bytes[i]) line_bytes[i] = '0;
      upper_half     = '0;
      entry_point    = '0;
      error_tally    = '0;
      checksum_tally = '0;
      record_tally   = '0;
      bytes_tally    = '0;
      limit_value    = MEMORY_LIMIT_RESET;
   endtask

   // Decode one character into the line fields
   task automatic absorb_char(input logic [7:0] c);
      logic [3:0]  nib;
      logic [7:0]  pair;
      int unsigned k;
      nib = digit_value(c);
      if (line_pos >= LINE_MAX_POS) return;
      if (line_pos == 8) type_letter = c;
      if (line_pos % 2 == 1) begin
         high_digit = nib;
      end else if (line_pos >= 2) begin
         pair = {high_digit, nib};
         k = (line_pos - 2) / 2;
         if (k == 0) length_byte = pair;
         else if (k == 1) line_offset[15:8] = pair;
         else if (k == 2) line_offset[7:0] = pair;
         else if (k >= 4 && k - 4 < BUF_BYTES) line_bytes[k - 4] = pair;
         // The type pair stays out of the sum; its own term is added at judgement
         if (k != 3) byte_sum = byte_sum + pair;
      end
      line_pos++;
   endtask

   // Judge a finished line and queue the writes and the status item it produces
   task automatic finish_line;
      int unsigned seen_len;
      int unsigned needed_len;
      logic [31:0] base;
      logic [33:0] end_addr;
      logic [7:0]  sum_check;
      logic [3:0]  verdict;
      hex_result_type r;
      seen_len   = (line_pos >= LINE_MAX_POS) ? LINE_MAX_POS + 1 : line_pos;
      needed_len = 11 + 2 * length_byte;
      base       = {upper_half, line_offset};
      sum_check  = byte_sum + (type_letter - CHAR_ZERO);
      if (seen_len != needed_len) begin
         error_tally = count_up(error_tally);
         verdict = ST_LENGTH;
      end else if (length_byte > BUF_BYTES) begin
         error_tally = count_up(error_tally);
         verdict = ST_TOO_LONG;
      end else if (sum_check != 8'd0) begin
         checksum_tally = count_up(checksum_tally);
         verdict = ST_CHECKSUM;
      end else begin
         record_tally = count_up(record_tally);
         if (type_letter == TYPE_DATA) begin
            end_addr = {2'b00, base} + 34'(length_byte);
            if (end_addr > {1'b0, limit_value}) begin
               error_tally = count_up(error_tally);
               verdict = ST_BOUNDS;
            end else begin
               for (int i = 0; i < length_byte; i++) begin
                  r = '0;
                  r.kind    = KIND_WRITE;
                  r.address = base + 32'(i);
                  r.data    = line_bytes[i];
                  pending_outputs.push_back(r);
               end
               bytes_tally = bytes_tally + 32'(length_byte);
               verdict = ST_DATA_OK;
            end
         end else if (type_letter == TYPE_EXT_LIN) begin
            if (length_byte != EXT_LEN) begin
               error_tally = count_up(error_tally);
               verdict = ST_BAD_EXT;
            end else begin
               upper_half = {line_bytes[0], line_bytes[1]};
               verdict = ST_EXT_OK;
            end
         end else if (type_letter == TYPE_START) begin
            if (length_byte != START_LEN) begin
               verdict = ST_BAD_START;
            end else begin
               entry_point = {line_bytes[0], line_bytes[1], line_bytes[2], line_bytes[3]};
               verdict = ST_START_OK;
            end
         end else if (type_letter == TYPE_EOF) begin
            verdict = ST_EOF;
         end else begin
            verdict = ST_UNKNOWN;
         end
      end
      r = '0;
      r.kind       = KIND_STATUS;
      r.status     = verdict;
      r.rtype      = type_letter;
      r.start      = entry_point;
      r.errors     = error_tally;
      r.cks_errors = checksum_tally;
      r.records    = record_tally;
      r.bytes      = bytes_tally;
      r.last       = 1'b1;
      pending_outputs.push_back(r);
      clear_line_state();
   endtask

   // ---------------------------------------------------------------- drivers

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!sender_idles || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Send one character request; valid stays high until the next gap or drain
   task automatic send_char(input logic [7:0] c, input logic flag_end);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid    <= 1'b1;
      req_bus.ch       <= c;
      req_bus.line_end <= flag_end;
      do @(posedge clock); while (!req_bus.ready);
      chars_sent++;
      absorb_char(c);
      if (flag_end) finish_line();
   endtask

   task automatic send_line;
      foreach (line_text[i]) send_char(line_text[i], i == line_text.size() - 1);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
      if (nib < 4'd10) return 8'("0") + 8'(nib);
      return (lower ? 8'("a") : 8'("A")) + 8'(nib) - 8'd10;
   endfunction

   task automatic append_byte(input logic [7:0] b, input bit lower);
      line_text.push_back(hex_char(b[7:4], lower));
      line_text.push_back(hex_char(b[3:0], lower));
   endtask

   // Build ":LLAAAATTDD..CC" from the payload array into line_text
   task automatic compose_record(input logic [7:0] kind_char, input int len,
                                 input logic [15:0] addr, input bit good_sum);
      logic [7:0] total;
      logic [7:0] cks;
      bit         lower;
      lower = $urandom_range(0, 1);
      total = 8'(len) + addr[15:8] + addr[7:0] + (kind_char - CHAR_ZERO);
      line_text.delete();
      line_text.push_back(":");
      append_byte(8'(len), lower);
      append_byte(addr[15:8], lower);
      append_byte(addr[7:0], lower);
      line_text.push_back("0");
      line_text.push_back(kind_char);
      for (int i = 0; i < len; i++) begin
         append_byte(payload[i], lower);
         total = total + payload[i];
      end
      cks = 8'd0 - total;
      if (!good_sum) cks = cks ^ 8'($urandom_range(1, 255));
      append_byte(cks, lower);
   endtask

   task automatic send_record(input logic [7:0] kind_char, input int len,
                              input logic [15:0] addr, input bit good_sum);
      compose_record(kind_char, len, addr, good_sum);
      send_line();
   endtask

   task automatic fill_payload(input int len);
      for (int i = 0; i < len; i++) payload[i] = 8'($urandom);
   endtask

   task automatic set_upper(input logic [15:0] u);
      payload[0] = u[15:8];
      payload[1] = u[7:0];
      send_record(TYPE_EXT_LIN, 2, 16'h0000, 1'b1);
   endtask

   // Stop sending and let every predicted result arrive
   task automatic wait_for_idle;
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write the memory limit while the block is idle, then read it back
   task automatic set_limit(input logic [32:0] v);
      wait_for_idle();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {CSR_MEMORY_LIMIT, 3'b000};
      pwdata  <= {31'd0, v};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      limit_value = v;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[32:0] !== limit_value) begin
         log_failure($sformatf("memory limit read back %h, expected %h",
                               prdata[32:0], limit_value));
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // ---------------------------------------------------------------- tests

   // Every record type on well-formed lines, including a full buffer
   task automatic test_record_kinds;
      for (int i = 0; i < BUF_BYTES; i++) payload[i] = (i % 2 == 0) ? 8'h00 : 8'hFF;
      send_record(TYPE_DATA, BUF_BYTES, 16'hFFE0, 1'b1);
      send_record(TYPE_EOF, 0, 16'h0000, 1'b1);
      set_upper(16'h0001);
      fill_payload(2);
      send_record(TYPE_DATA, 2, 16'h8000, 1'b1);
      fill_payload(4);
      send_record(TYPE_START, 4, 16'h0000, 1'b1);
      send_record("Z", 0, 16'h0001, 1'b1);
      set_upper(16'h0000);
   endtask

   // Broken lines: length faults, an oversize record, bad sums, bad lengths, junk digits
   task automatic test_line_faults;
      line_text.delete();
      line_text.push_back(":");
      send_line();
      payload[0] = 8'h3C;
      compose_record(TYPE_DATA, 1, 16'h0010, 1'b1);
      void'(line_text.pop_back());
      send_line();
      fill_payload(BUF_BYTES + 1);
      send_record(TYPE_DATA, BUF_BYTES + 1, 16'h0000, 1'b1);
      send_record(TYPE_DATA, 1, 16'h0040, 1'b0);
      fill_payload(2);
      send_record(TYPE_EXT_LIN, 1, 16'h0000, 1'b1);
      send_record(TYPE_START, 0, 16'h0000, 1'b1);
      // Non-hex characters decode as zero, here inside the data and in the address
      fill_payload(1);
      compose_record(TYPE_DATA, 1, 16'h0100, 1'b1);
      line_text[10] = "G";
      line_text[4]  = 8'hC7;
      send_line();
   endtask

   // Bounds at a zero limit, at the top of the address space and exactly at the limit
   task automatic test_memory_limit;
      set_limit(33'd0);
      send_record(TYPE_DATA, 0, 16'h0000, 1'b1);
      payload[0] = 8'h11;
      send_record(TYPE_DATA, 1, 16'h0000, 1'b1);
      set_limit(33'h1_0000_0000);
      set_upper(16'hFFFF);
      fill_payload(2);
      send_record(TYPE_DATA, 1, 16'hFFFF, 1'b1);
      send_record(TYPE_DATA, 2, 16'hFFFF, 1'b1);
      set_upper(16'h0000);
      set_limit(33'h0_0001_0000);
      send_record(TYPE_DATA, 1, 16'hFFFF, 1'b1);
      send_record(TYPE_DATA, 2, 16'hFFFF, 1'b1);
      set_limit(MEMORY_LIMIT_RESET);
   endtask

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 4);
      if (r < 95) return $urandom_range(5, BUF_BYTES);
      return $urandom_range(BUF_BYTES + 1, BUF_BYTES + 8);
   endfunction

   // One random line: mostly well-formed records, some junk and broken lines
   task automatic random_line;
      int          pick;
      int          len;
      int          stretch;
      logic [7:0]  kind_char;
      logic [15:0] value;
      bit          good;
      pick      = $urandom_range(0, 99);
      good      = ($urandom_range(0, 9) != 0);
      len       = pick_length();
      stretch   = 0;
      kind_char = TYPE_DATA;
      sender_idles    = ($urandom_range(0, 4) != 0);
      receiver_stalls = ($urandom_range(0, 4) != 0);
      fill_payload(len);
      if (pick < 85 && pick >= 45) begin
         if (pick < 60) begin
            kind_char = TYPE_EXT_LIN;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : 2;
            case ($urandom_range(0, 7))
               0, 1, 2, 3: value = 16'h0000;
               4, 5:       value = 16'h0001;
               6:          value = 16'hFFFF;
               default:    value = 16'($urandom);
            endcase
            payload[0] = value[15:8];
            payload[1] = value[7:0];
         end else if (pick < 70) begin
            kind_char = TYPE_START;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : 4;
            fill_payload(len);
         end else if (pick < 75) begin
            kind_char = TYPE_EOF;
            len = ($urandom_range(0, 3) == 0) ? len : 0;
         end else begin
            kind_char = 8'($urandom_range(0, 255));
         end
      end else if (pick >= 85 && pick < 92) begin
         line_text.delete();
         repeat ($urandom_range(1, 30)) line_text.push_back(8'($urandom_range(0, 255)));
         send_line();
         return;
      end else if (pick >= 92) begin
         stretch = $urandom_range(0, 1) ? $urandom_range(1, 3) : -$urandom_range(1, 3);
      end
      compose_record(kind_char, len, 16'($urandom), good);
      if ($urandom_range(0, 19) == 0) begin
         line_text[$urandom_range(0, line_text.size() - 1)] = 8'($urandom_range(0, 255));
      end
      if (stretch < 0) begin
         repeat (-stretch) void'(line_text.pop_back());
      end else begin
         repeat (stretch) line_text.push_back(hex_char(4'($urandom), 1'b0));
      end
      send_line();
      // Now and then hold the sender until everything has come out
      if ($urandom_range(0, 29) == 0) wait_for_idle();
   endtask

   task automatic run_random_lines(input int char_budget);
      int unsigned first;
      first = chars_sent;
      while (chars_sent - first < char_budget) random_line();
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;
   endtask

   // Random lines under the reset limit and under a random one
   task automatic test_random_records;
      run_random_lines(30);
      set_limit({1'b0, 32'($urandom)});
      run_random_lines(30);
      set_limit(MEMORY_LIMIT_RESET);
   endtask

   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.ch       = '0;
      req_bus.line_end = 1'b0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      failures         = 0;
      cycle_count      = 0;
      chars_sent       = 0;
      sender_idles     = 1'b1;
      receiver_stalls  = 1'b1;
      foreach (payload[i]) payload[i] = '0;
      reset_model();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_record_kinds();
      test_line_faults();
      test_memory_limit();
      test_random_records();

      receiver_stalls = 1'b0;
      wait_for_idle();
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
sv/ihex_pkg.sv
sv/ihex_req_if.sv
sv/ihex_rsp_if.sv
sv/ihex_ram.sv
sv/ihex_front.sv
sv/ihex_queue.sv
sv/ihex_back.sv
sv/intel_hex_record_parser.sv
sim/intel_hex_record_parser_tb.sv
